### hw/rtl/mmn_pkg.sv
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared types and constants for the multichannel min/max normalizer.
// ----------------------------------------------------------------------------
package mmn_pkg;

    // Defaults for the top-level parameters.
    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths.
    localparam int CHAN_W  = 3;
    localparam int LEVEL_W = 8;

    // Reset value of the full-scale register.
    localparam logic [LEVEL_W-1:0] FULL_SCALE_RESET = 8'd100;

    // The quotient never exceeds full scale, so it has LEVEL_W bits.
    localparam int QUO_BITS = LEVEL_W;
    localparam int CNT_W    = $clog2(QUO_BITS);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MULT,
        ST_DIVIDE,
        ST_FINISH
    } mmn_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic update;
        logic mult;
        logic div_step;
        logic emit;
    } mmn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } mmn_status_t;

endpackage

### hw/rtl/multichannel_minmax_normalizer.sv
// ----------------------------------------------------------------------------
// multichannel_minmax_normalizer
// Per-channel running min/max tracker that scales each sample into
// 0..full_scale.
// ----------------------------------------------------------------------------
// Each accepted sample updates its channel's running minimum (or, if not
// below it, the running maximum) and returns one result with the sample
// scaled to (sample - min) * full_scale / (max - min), truncated, or level 0
// with not_ready set while the channel's maximum is not above its minimum or
// the channel number is not below CHANNELS. From transfer in to the result
// standing in the output register an item passes through these steps: accept,
// the min/max update, the multiply, the restoring divider that produces one
// quotient bit per cycle, and the load of the output register. A new sample
// is taken while the previous result still waits in the output register; a
// stalled output holds the next result back in its last step.
module multichannel_minmax_normalizer #(
    parameter int CHANNELS    = mmn_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mmn_pkg::LEVEL_W-1:0]   full_scale,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mmn_pkg::CHAN_W-1:0]    channel,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mmn_pkg::CHAN_W-1:0]    out_channel,
    output logic [mmn_pkg::LEVEL_W-1:0]   level,
    output logic                          not_ready,
    output logic [SAMPLE_BITS-1:0]        low_mark,
    output logic [SAMPLE_BITS-1:0]        high_mark
);
    import mmn_pkg::*;

    mmn_cmd_t    cmd;
    mmn_status_t status;

    // The configuration register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    mmn_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mmn_datapath #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_valid),
        .cfg_full_scale (full_scale),
        .channel        (channel),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_channel    (out_channel),
        .level          (level),
        .not_ready      (not_ready),
        .low_mark       (low_mark),
        .high_mark      (high_mark)
    );

`ifndef NO_ASSERTIONS
    // A result with an open range must show a minimum below its maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !not_ready) |-> (low_mark < high_mark))
    else $error("ready result with closed range");

    // A not-ready result always reports level zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && not_ready) |-> (level == '0))
    else $error("not-ready result with nonzero level");

    // After an input transfer the block is busy with that item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && cmd.update))
    else $error("input transfer not followed by update");
`endif

endmodule

### hw/rtl/mmn_controller.sv
// ----------------------------------------------------------------------------
// mmn_controller
// Sequencer for the normalizer: accept, update, multiply, divide, emit.
// ----------------------------------------------------------------------------
module mmn_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mmn_pkg::mmn_status_t status,
    output mmn_pkg::mmn_cmd_t    cmd
);
    import mmn_pkg::*;

    mmn_state_t        state_reg;
    mmn_state_t        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    // State and divider step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                state_next = ST_DIVIDE;
                cnt_next   = '0;
            end
            ST_DIVIDE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_BITS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_MULT:
            begin
                cmd.mult = 1'b1;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/mmn_datapath.sv
// ----------------------------------------------------------------------------
// mmn_datapath
// Per-channel min/max store, scaling multiplier, restoring divider and
// output register of the normalizer.
// ----------------------------------------------------------------------------
module mmn_datapath #(
    parameter int CHANNELS    = mmn_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mmn_pkg::mmn_cmd_t             cmd,
    output mmn_pkg::mmn_status_t          status,
    input  logic                          cfg_we,
    input  logic [mmn_pkg::LEVEL_W-1:0]   cfg_full_scale,
    input  logic [mmn_pkg::CHAN_W-1:0]    channel,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mmn_pkg::CHAN_W-1:0]    out_channel,
    output logic [mmn_pkg::LEVEL_W-1:0]   level,
    output logic                          not_ready,
    output logic [SAMPLE_BITS-1:0]        low_mark,
    output logic [SAMPLE_BITS-1:0]        high_mark
);
    import mmn_pkg::*;

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = SAMPLE_BITS + LEVEL_W;

    logic [LEVEL_W-1:0]     fs_reg;
    logic [SAMPLE_BITS-1:0] low_reg  [CHANNELS];
    logic [SAMPLE_BITS-1:0] high_reg [CHANNELS];

    logic [CHAN_W-1:0]      chan_reg;
    logic [SAMPLE_BITS-1:0] samp_reg;
    logic [SAMPLE_BITS-1:0] lo_reg;
    logic [SAMPLE_BITS-1:0] hi_reg;
    logic [SAMPLE_BITS-1:0] num_reg;
    logic [SAMPLE_BITS-1:0] den_reg;
    logic                   nr_reg;
    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [QUO_BITS-1:0]    quo_reg;

    logic                   out_valid_reg;
    logic [CHAN_W-1:0]      out_channel_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic                   not_ready_reg;
    logic [SAMPLE_BITS-1:0] low_mark_reg;
    logic [SAMPLE_BITS-1:0] high_mark_reg;

    logic                   chan_ok;
    logic [IDX_W-1:0]       idx;
    logic [SAMPLE_BITS-1:0] cur_lo;
    logic [SAMPLE_BITS-1:0] cur_hi;
    logic                   below;
    logic [SAMPLE_BITS-1:0] new_lo;
    logic [SAMPLE_BITS-1:0] new_hi;
    logic                   range_open;
    logic [PROD_W-1:0]      prod;
    logic [SAMPLE_BITS:0]   trial;
    logic [SAMPLE_BITS:0]   diff;
    logic                   fits;

    // Full-scale configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= FULL_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            fs_reg <= cfg_full_scale;
        end
    end

    // Channel lookup and the min-first, else max, update rule.
    always_comb
    begin
        chan_ok    = (32'(chan_reg) < 32'(CHANNELS));
        idx        = IDX_W'(chan_reg);
        cur_lo     = low_reg[idx];
        cur_hi     = high_reg[idx];
        below      = (samp_reg < cur_lo);
        new_lo     = below ? samp_reg : cur_lo;
        new_hi     = (!below && (samp_reg > cur_hi)) ? samp_reg : cur_hi;
        range_open = (new_hi > new_lo);
    end

    // Running minimum and maximum for every channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                low_reg[i]  <= '1;
                high_reg[i] <= '0;
            end
        end
        else if (cmd.update && chan_ok)
        begin
            low_reg[idx]  <= new_lo;
            high_reg[idx] <= new_hi;
        end
    end

    // Scaling product and one restoring divider step.
    always_comb
    begin
        prod  = PROD_W'(num_reg) * PROD_W'(fs_reg);
        trial = {rem_reg, quo_reg[QUO_BITS-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Item registers: capture, update results, multiply, divide.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            chan_reg <= channel;
            samp_reg <= sample;
        end
        if (cmd.update)
        begin
            lo_reg  <= chan_ok ? new_lo : '0;
            hi_reg  <= chan_ok ? new_hi : '0;
            num_reg <= samp_reg - new_lo;
            den_reg <= new_hi - new_lo;
            nr_reg  <= !(chan_ok && range_open);
        end
        if (cmd.mult)
        begin
            // The quotient fits in QUO_BITS, so the upper part starts below den.
            rem_reg <= prod[PROD_W-1:QUO_BITS];
            quo_reg <= prod[QUO_BITS-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            quo_reg <= {quo_reg[QUO_BITS-2:0], fits};
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_channel_reg <= chan_reg;
            level_reg       <= nr_reg ? '0 : quo_reg;
            not_ready_reg   <= nr_reg;
            low_mark_reg    <= lo_reg;
            high_mark_reg   <= hi_reg;
        end
    end

    // The output register can take a result when empty or when it drains now.
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign level       = level_reg;
    assign not_ready   = not_ready_reg;
    assign low_mark    = low_mark_reg;
    assign high_mark   = high_mark_reg;

endmodule
